### hdl/tile_display_dot_engine_macros.svh
// ---------------------------------------------------------------------------
// tile_display_dot_engine_macros
// Assertion macros shared by the dot engine RTL.
// ---------------------------------------------------------------------------
`ifndef TILE_DISPLAY_DOT_ENGINE_MACROS_SVH
`define TILE_DISPLAY_DOT_ENGINE_MACROS_SVH
`ifndef ASSERT_OFF
`define TDD_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("tdd assertion failed");
`define TDD_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("tdd assertion failed");
`else
`define TDD_ASSERT(lbl, clk, rstn, prop)
`define TDD_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

### hdl/tdd_pkg.sv
// ---------------------------------------------------------------------------
// tdd_pkg
// Types and fixed constants of the tile display dot engine.
// ---------------------------------------------------------------------------
`default_nettype none
package tdd_pkg;

  localparam int QUEUE_DEPTH    = 8;
  localparam int TILE_MEM_DEPTH = 8192;
  localparam int TILE_AW        = 13;
  localparam int OBJ_ROWS       = 40;
  localparam int OBJ_RW         = 6;

  localparam logic [12:0] OBJ_MEM_BYTES   = 13'd160;
  localparam logic [8:0]  DOTS_PER_LINE   = 9'd456;
  localparam logic [8:0]  LAST_SEARCH_DOT = 9'd79;
  localparam logic [7:0]  TOTAL_LINES     = 8'd154;
  localparam logic [2:0]  MAP_HI          = 3'b110;
  localparam int          PAL_FLAG_BIT    = 4;

  localparam logic [1:0] FUNC_TICK   = 2'd0;
  localparam logic [1:0] FUNC_TILE_WR = 2'd1;
  localparam logic [1:0] FUNC_OBJ_WR = 2'd2;

  localparam logic [1:0] PH_HBLANK = 2'd0;
  localparam logic [1:0] PH_VBLANK = 2'd1;
  localparam logic [1:0] PH_SEARCH = 2'd2;
  localparam logic [1:0] PH_DRAW   = 2'd3;

  localparam logic [2:0] REG_SCROLL_Y   = 3'd0;
  localparam logic [2:0] REG_BG_PAL     = 3'd1;
  localparam logic [2:0] REG_OBJ_PAL0   = 3'd2;
  localparam logic [2:0] REG_OBJ_PAL1   = 3'd3;
  localparam logic [2:0] REG_DISPLAY_ON = 3'd4;
  localparam logic [2:0] REG_LINE_CMP   = 3'd5;

  typedef struct packed {
    logic               tile_we;
    logic               obj_we;
    logic [TILE_AW-1:0] wr_addr;
    logic [7:0]         wr_data;
    logic               tile_re;
    logic [TILE_AW-1:0] tile_raddr;
    logic               obj_re;
    logic [OBJ_RW-1:0]  obj_row;
  } mem_req_t;

endpackage
`default_nettype wire

### hdl/tdd_mem.sv
// ---------------------------------------------------------------------------
// tdd_mem
// Tile memory (byte wide) and object memory (four bytes per row).
// ---------------------------------------------------------------------------
`default_nettype none
module tdd_mem import tdd_pkg::*; (
  input  wire logic        clk,
  input  wire mem_req_t    req,
  output logic [7:0]       tile_rdata_r,
  output logic [31:0]      obj_rdata_r
);

  logic [7:0]  tile_mem [TILE_MEM_DEPTH];
  logic [31:0] obj_mem  [OBJ_ROWS];

  always_ff @(posedge clk) begin
    if (req.tile_we) begin
      tile_mem[req.wr_addr] <= req.wr_data;
    end
    if (req.tile_re) begin
      tile_rdata_r <= tile_mem[req.tile_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (req.obj_we) begin
      obj_mem[req.wr_addr[7:2]][{req.wr_addr[1:0], 3'b000} +: 8] <= req.wr_data;
    end
    if (req.obj_re) begin
      obj_rdata_r <= obj_mem[req.obj_row];
    end
  end

endmodule
`default_nettype wire

### hdl/tile_display_dot_engine.sv
// The result of a request is registered and offered in the cycle after acceptance.
// Throughput: one request per cycle while out_ready keeps the output free; each tick is folded
// into the state at once and the memory read it may issue is absorbed in the following cycle.
// Output register holds one result; the input stalls only while it waits with out_ready low.
// Reset: synchronous, active low; counters and queues clear at once, memories keep contents.
// ---------------------------------------------------------------------------
// tile_display_dot_engine
// Dot-stepped tile display engine with object search, fetcher and pixel queues.
// ---------------------------------------------------------------------------
`default_nettype none
`include "tile_display_dot_engine_macros.svh"
module tile_display_dot_engine import tdd_pkg::*; #(
  parameter int VISIBLE_WIDTH    = 160,
  parameter int VISIBLE_LINES    = 144,
  parameter int MAX_LINE_OBJECTS = 10
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  in_func,
  input  wire logic [12:0] in_mem_addr,
  input  wire logic [7:0]  in_mem_data,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             out_pixel_valid,
  output logic [7:0]       out_pixel_x,
  output logic [7:0]       out_pixel_y,
  output logic [1:0]       out_shade,
  output logic             out_blank_pixel,
  output logic [1:0]       out_mode,
  output logic [7:0]       out_line,
  output logic             out_line_match,
  output logic             out_vblank_irq,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  localparam int CNT_W = $clog2(MAX_LINE_OBJECTS + 1);
  localparam int IDX_W = (MAX_LINE_OBJECTS > 1) ? $clog2(MAX_LINE_OBJECTS) : 1;
  localparam logic [7:0] VIS_W = 8'(VISIBLE_WIDTH);
  localparam logic [7:0] VIS_L = 8'(VISIBLE_LINES);
  localparam logic [CNT_W-1:0] MAX_OBJ = CNT_W'(MAX_LINE_OBJECTS);
  localparam logic [3:0] Q_EMPTY = 4'(QUEUE_DEPTH);

  // follow-up work on memory read data, in the cycle after the request
  localparam logic [2:0] SB_NONE = 3'd0;
  localparam logic [2:0] SB_TILE = 3'd1;
  localparam logic [2:0] SB_B0   = 3'd2;
  localparam logic [2:0] SB_B1   = 3'd3;
  localparam logic [2:0] SB_OBJ  = 3'd4;

  logic [7:0] scroll_y_r, bg_pal_r, obp0_r, obp1_r, lyc_r;
  logic       disp_on_r;

  logic [1:0]       phase_r, phase_nxt;
  logic [8:0]       dot_r, dot_nxt;
  logic [7:0]       line_r, line_nxt;
  logic [7:0]       col_r, col_nxt;
  logic [CNT_W-1:0] obj_total_r, obj_total_nxt;
  logic [CNT_W-1:0] next_obj_r, next_obj_nxt;
  logic [2:0]       step_r, step_nxt;
  logic [4:0]       tile_col_r, tile_col_nxt;
  logic [7:0]       fy_r, fy_nxt, ftile_r, ftile_nxt, fb0_r, fb0_nxt, fb1_r, fb1_nxt;
  logic             fpal_r, fpal_nxt;
  logic             obj_mode_r, obj_mode_nxt;
  logic [7:0]       bgq0_r, bgq0_nxt, bgq1_r, bgq1_nxt;
  logic [3:0]       bg_idx_r, bg_idx_nxt;
  logic [7:0]       obq0_r, obq0_nxt, obq1_r, obq1_nxt;
  logic             obq_pal_r, obq_pal_nxt;
  logic [3:0]       ob_idx_r, ob_idx_nxt;
  logic             match_r, match_nxt;
  logic [2:0]       sb_kind_r, sb_kind_nxt;
  logic             sb_dot0_r, sb_dot0_nxt;
  logic [31:0]      lo_r [MAX_LINE_OBJECTS];

  logic             out_valid_r, out_pix_r, out_blank_r, out_match_r, out_irq_r;
  logic [7:0]       out_x_r, out_y_r, out_line_r;
  logic [1:0]       out_shade_r, out_mode_r;

  mem_req_t   mreq;
  logic [7:0] tile_rdata;
  logic [31:0] obj_rdata;

  logic             accept;
  logic [CNT_W-1:0] lo_sel, obj_base;
  logic             lo_ok, obj_hit;
  logic [31:0]      lo_word;
  logic             pv, blank, irq;
  logic [7:0]       px, py;
  logic [1:0]       sh, color, ocolor;
  logic [7:0]       pal;
  logic [2:0]       bsel, osel;
  logic [8:0]       dot_inc, ly16, ly8;
  logic [7:0]       line_inc;

  tdd_mem u_mem (
    .clk          (clk),
    .req          (mreq),
    .tile_rdata_r (tile_rdata),
    .obj_rdata_r  (obj_rdata)
  );

  assign in_ready = ~out_valid_r | out_ready;
  assign accept   = in_valid & in_ready;

  // one line object read port: the following object at the end of an object fetch
  always_comb begin
    lo_sel  = (step_r == 3'd7 && obj_mode_r) ? CNT_W'(next_obj_r + 1'b1) : next_obj_r;
    lo_ok   = lo_sel < obj_total_r;
    lo_word = lo_ok ? lo_r[lo_sel[IDX_W-1:0]] : '0;
  end

  // object search result from the previous cycle's read
  always_comb begin
    ly16     = {1'b0, line_r} + 9'd16;
    ly8      = {1'b0, line_r} + 9'd8;
    obj_base = sb_dot0_r ? '0 : obj_total_r;
    obj_hit  = (sb_kind_r == SB_OBJ) && (obj_base < MAX_OBJ) && (obj_rdata[15:8] != 8'd0)
               && ({1'b0, obj_rdata[7:0]} <= ly16) && ({1'b0, obj_rdata[7:0]} > ly8);
  end

  always_comb begin
    phase_nxt = phase_r;     dot_nxt = dot_r;          line_nxt = line_r;
    col_nxt = col_r;         next_obj_nxt = next_obj_r; step_nxt = step_r;
    tile_col_nxt = tile_col_r;
    fy_nxt = fy_r;           fpal_nxt = fpal_r;
    ftile_nxt = (sb_kind_r == SB_TILE) ? tile_rdata : ftile_r;
    fb0_nxt   = (sb_kind_r == SB_B0)   ? tile_rdata : fb0_r;
    fb1_nxt   = (sb_kind_r == SB_B1)   ? tile_rdata : fb1_r;
    obj_total_nxt = (sb_kind_r == SB_OBJ) ? CNT_W'(obj_base + CNT_W'(obj_hit)) : obj_total_r;
    obj_mode_nxt = obj_mode_r;
    bgq0_nxt = bgq0_r; bgq1_nxt = bgq1_r; bg_idx_nxt = bg_idx_r;
    obq0_nxt = obq0_r; obq1_nxt = obq1_r; obq_pal_nxt = obq_pal_r; ob_idx_nxt = ob_idx_r;
    match_nxt = match_r;
    sb_kind_nxt = SB_NONE;   sb_dot0_nxt = 1'b0;
    pv = 1'b0; px = '0; py = '0; sh = '0; blank = 1'b0; irq = 1'b0;
    color = '0; ocolor = '0; pal = bg_pal_r; bsel = '0; osel = '0;
    dot_inc = 9'(dot_r + 1'b1);
    line_inc = 8'(line_r + 1'b1);
    mreq = '0;
    mreq.wr_addr = in_mem_addr;
    mreq.wr_data = in_mem_data;
    if (accept) begin
      unique case (in_func)
        FUNC_TILE_WR: begin
          mreq.tile_we = 1'b1;
        end
        FUNC_OBJ_WR: begin
          mreq.obj_we = in_mem_addr < OBJ_MEM_BYTES;
        end
        FUNC_TICK: begin
          if (phase_r == PH_SEARCH) begin
            if (!dot_r[0]) begin
              mreq.obj_re  = 1'b1;
              mreq.obj_row = dot_r[6:1];
              sb_kind_nxt  = SB_OBJ;
              sb_dot0_nxt  = (dot_r == 9'd0);
            end
            if (dot_r == LAST_SEARCH_DOT) begin
              phase_nxt    = PH_DRAW;
              col_nxt      = '0;
              obj_mode_nxt = 1'b0;
              bg_idx_nxt   = Q_EMPTY;
              ob_idx_nxt   = Q_EMPTY;
              next_obj_nxt = '0;
              step_nxt     = '0;
              tile_col_nxt = '0;
            end
          end else if (phase_r == PH_DRAW) begin
            unique case (step_r)
              3'd0: begin
                if (obj_mode_r) begin
                  fy_nxt    = 8'(line_r - lo_word[7:0]);
                  ftile_nxt = lo_word[23:16];
                  fpal_nxt  = lo_word[24 + PAL_FLAG_BIT];
                end else begin
                  fy_nxt          = 8'(line_r + scroll_y_r);
                  mreq.tile_re    = 1'b1;
                  mreq.tile_raddr = {MAP_HI, fy_nxt[7:3], tile_col_r};
                  sb_kind_nxt     = SB_TILE;
                end
              end
              3'd2: begin
                mreq.tile_re    = 1'b1;
                mreq.tile_raddr = {1'b0, ftile_r, fy_r[2:0], 1'b0};
                sb_kind_nxt     = SB_B0;
              end
              3'd4: begin
                mreq.tile_re    = 1'b1;
                mreq.tile_raddr = {1'b0, ftile_r, fy_r[2:0], 1'b1};
                sb_kind_nxt     = SB_B1;
              end
              3'd6: begin
                if (!obj_mode_r) tile_col_nxt = 5'(tile_col_r + 1'b1);
              end
              3'd7: begin
                if (obj_mode_r) begin
                  // drop the load while the queue still holds pixels
                  if (ob_idx_r[3]) begin
                    obq0_nxt = fb0_r; obq1_nxt = fb1_r; obq_pal_nxt = fpal_r;
                    ob_idx_nxt = '0;
                  end
                  next_obj_nxt = CNT_W'(next_obj_r + 1'b1);
                  if (!lo_ok) begin
                    obj_mode_nxt = 1'b0;
                  end else if ({1'b0, lo_word[15:8]} > ({1'b0, col_r} + 9'd8)) begin
                    obj_mode_nxt = 1'b0;
                  end
                end else begin
                  if (bg_idx_r[3]) begin
                    bgq0_nxt = fb0_r; bgq1_nxt = fb1_r; bg_idx_nxt = '0;
                  end
                  if (lo_ok && ({1'b0, lo_word[15:8]} == ({1'b0, col_r} + 9'd8))) begin
                    obj_mode_nxt = 1'b1;
                  end
                end
              end
              default: ;
            endcase
            step_nxt = 3'(step_r + 1'b1);

            if (!obj_mode_nxt && !bg_idx_nxt[3]) begin
              bsel       = bg_idx_nxt[2:0];
              color      = {bgq1_nxt[~bsel], bgq0_nxt[~bsel]};
              bg_idx_nxt = 4'(bg_idx_nxt + 1'b1);
              if (!ob_idx_nxt[3]) begin
                osel       = ob_idx_nxt[2:0];
                ocolor     = {obq1_nxt[~osel], obq0_nxt[~osel]};
                ob_idx_nxt = 4'(ob_idx_nxt + 1'b1);
                if (ocolor != 2'd0) begin
                  color = ocolor;
                  pal   = obq_pal_nxt ? obp1_r : obp0_r;
                end
              end
              if (col_r < VIS_W) begin
                pv = 1'b1;
                px = col_r;
                py = line_r;
                if (!disp_on_r) begin
                  blank = 1'b1;
                  sh    = 2'd3;
                end else begin
                  sh = pal[{color, 1'b0} +: 2];
                end
                col_nxt = 8'(col_r + 1'b1);
              end
            end
            if (col_nxt == VIS_W) phase_nxt = PH_HBLANK;
          end

          if (dot_inc == DOTS_PER_LINE) begin
            dot_nxt  = '0;
            line_nxt = line_inc;
            if (line_inc < VIS_L) begin
              phase_nxt = PH_SEARCH;
            end else if (line_inc == VIS_L) begin
              phase_nxt = PH_VBLANK;
              irq       = 1'b1;
            end else if (line_inc >= TOTAL_LINES) begin
              line_nxt  = '0;
              phase_nxt = PH_SEARCH;
            end
            match_nxt = (line_nxt == lyc_r);
          end else begin
            dot_nxt = dot_inc;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_SEARCH;  dot_r <= '0;        line_r <= '0;      col_r <= '0;
      obj_total_r <= '0;     next_obj_r <= '0;   step_r <= '0;      tile_col_r <= '0;
      obj_mode_r <= 1'b0;    bg_idx_r <= Q_EMPTY; ob_idx_r <= Q_EMPTY;
      match_r <= 1'b0;       sb_kind_r <= SB_NONE; sb_dot0_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r <= phase_nxt;  dot_r <= dot_nxt;   line_r <= line_nxt; col_r <= col_nxt;
      obj_total_r <= obj_total_nxt; next_obj_r <= next_obj_nxt;
      step_r <= step_nxt;    tile_col_r <= tile_col_nxt;
      obj_mode_r <= obj_mode_nxt; bg_idx_r <= bg_idx_nxt; ob_idx_r <= ob_idx_nxt;
      match_r <= match_nxt;  sb_kind_r <= sb_kind_nxt; sb_dot0_r <= sb_dot0_nxt;
      out_valid_r <= accept | (out_valid_r & ~out_ready);
    end
  end

  always_ff @(posedge clk) begin
    fy_r <= fy_nxt;  ftile_r <= ftile_nxt; fb0_r <= fb0_nxt; fb1_r <= fb1_nxt;
    fpal_r <= fpal_nxt;
    bgq0_r <= bgq0_nxt; bgq1_r <= bgq1_nxt;
    obq0_r <= obq0_nxt; obq1_r <= obq1_nxt; obq_pal_r <= obq_pal_nxt;
    if (obj_hit) begin
      lo_r[obj_base[IDX_W-1:0]] <= obj_rdata;
    end
    if (accept) begin
      out_pix_r   <= pv;    out_x_r <= px;      out_y_r <= py;
      out_shade_r <= sh;    out_blank_r <= blank;
      out_mode_r  <= phase_nxt; out_line_r <= line_nxt;
      out_match_r <= match_nxt; out_irq_r <= irq;
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scroll_y_r <= '0; bg_pal_r <= '0; obp0_r <= '0; obp1_r <= '0;
      disp_on_r <= 1'b1; lyc_r <= '0;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[4:2])
        REG_SCROLL_Y:   scroll_y_r <= pwdata[7:0];
        REG_BG_PAL:     bg_pal_r   <= pwdata[7:0];
        REG_OBJ_PAL0:   obp0_r     <= pwdata[7:0];
        REG_OBJ_PAL1:   obp1_r     <= pwdata[7:0];
        REG_DISPLAY_ON: disp_on_r  <= pwdata[0];
        REG_LINE_CMP:   lyc_r      <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:2])
      REG_SCROLL_Y:   prdata = {24'd0, scroll_y_r};
      REG_BG_PAL:     prdata = {24'd0, bg_pal_r};
      REG_OBJ_PAL0:   prdata = {24'd0, obp0_r};
      REG_OBJ_PAL1:   prdata = {24'd0, obp1_r};
      REG_DISPLAY_ON: prdata = {31'd0, disp_on_r};
      REG_LINE_CMP:   prdata = {24'd0, lyc_r};
      default:        prdata = '0;
    endcase
  end
  assign pready = 1'b1;

  assign out_valid       = out_valid_r;
  assign out_pixel_valid = out_pix_r;
  assign out_pixel_x     = out_x_r;
  assign out_pixel_y     = out_y_r;
  assign out_shade       = out_shade_r;
  assign out_blank_pixel = out_blank_r;
  assign out_mode        = out_mode_r;
  assign out_line        = out_line_r;
  assign out_line_match  = out_match_r;
  assign out_vblank_irq  = out_irq_r;

  `TDD_ASSERT(a_pix_phase, clk, rst_n, out_valid_r && out_pix_r |-> out_mode_r == PH_DRAW || out_mode_r == PH_HBLANK)
  `TDD_ASSERT(a_irq_line, clk, rst_n, out_valid_r && out_irq_r |-> out_line_r == VIS_L && out_mode_r == PH_VBLANK)
  `TDD_ASSERT(a_queue_idx, clk, rst_n, bg_idx_r <= Q_EMPTY && ob_idx_r <= Q_EMPTY)
  `TDD_ASSERT_NEXT(a_draw_start, clk, rst_n, accept && in_func == FUNC_TICK && phase_r == PH_SEARCH && dot_r == LAST_SEARCH_DOT, phase_r == PH_DRAW && sb_kind_r == SB_NONE)

endmodule
`default_nettype wire

### tb/sv/tb_tile_display_dot_engine.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_tile_display_dot_engine
// Self-checking bench: fills the tile, map and object bytes that can be read,
// runs dot ticks mixed with memory writes under changing palettes, scroll,
// display enable and line compare, and checks every result against a dot
// predictor.
// ---------------------------------------------------------------------------
module tb_tile_display_dot_engine;
  import tdd_pkg::*;

  localparam int VIS_W      = 160;
  localparam int VIS_LINES  = 144;
  localparam int MAX_OBJS   = 10;
  localparam int OBJ_BYTES  = 160;
  localparam int MAP_BASE   = 'h1800;
  localparam int READ_TOP   = 'h1c00;  // map ends here; nothing above is ever read
  localparam int STALL_LIMIT = 5000;
  localparam int TILE_SET   = 4;       // tiles used by the map and by objects
  localparam int MAP_ROW_HI = 16;      // map row 16, the second row filled, used where line plus scroll is 0x80..0x87
  localparam int HOLD_OFF_CYCLES = 400;

  typedef struct packed {
    logic       pixel_valid;
    logic [7:0] pixel_x;
    logic [7:0] pixel_y;
    logic [1:0] shade;
    logic       blank_pixel;
    logic [1:0] mode;
    logic [7:0] line;
    logic       line_match;
    logic       vblank_irq;
  } dot_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  in_func = FUNC_TICK;
  logic [12:0] in_mem_addr = '0;
  logic [7:0]  in_mem_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        out_pixel_valid;
  logic [7:0]  out_pixel_x;
  logic [7:0]  out_pixel_y;
  logic [1:0]  out_shade;
  logic        out_blank_pixel;
  logic [1:0]  out_mode;
  logic [7:0]  out_line;
  logic        out_line_match;
  logic        out_vblank_irq;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  tile_display_dot_engine i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_func(in_func), .in_mem_addr(in_mem_addr), .in_mem_data(in_mem_data),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_pixel_valid(out_pixel_valid), .out_pixel_x(out_pixel_x),
    .out_pixel_y(out_pixel_y), .out_shade(out_shade),
    .out_blank_pixel(out_blank_pixel), .out_mode(out_mode), .out_line(out_line),
    .out_line_match(out_line_match), .out_vblank_irq(out_vblank_irq),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // traffic shaping
  int   send_idle_pct = 0;
  int   recv_stall_pct = 0;
  logic hold_off_req = 1'b0;
  logic hold_off_seen = 1'b0;
  int   hold_off_left = 0;

  dot_result_t expected_dots[$];
  int mismatch_count = 0;
  int quiet_cycles = 0;

  // predictor: configuration
  logic [7:0] scroll_y_q = '0;
  logic [7:0] bg_pal_q = '0;
  logic [7:0] obj_pal0_q = '0;
  logic [7:0] obj_pal1_q = '0;
  logic       display_on_q = 1'b1;
  logic [7:0] line_cmp_q = '0;

  // predictor: display state
  logic [7:0]  tile_mem [0:TILE_MEM_DEPTH-1];
  logic [7:0]  obj_mem [0:OBJ_BYTES-1];
  logic [31:0] line_objs [0:MAX_OBJS-1];
  logic [1:0]  phase_q = PH_SEARCH;
  int          dot_q = 0;
  int          line_q = 0;
  int          col_q = 0;
  int          obj_cnt = 0;
  int          obj_next = 0;
  int          step_q = 0;
  int          map_col = 0;
  logic [7:0]  f_y = '0, f_tile = '0, f_flags = '0, f_b0 = '0, f_b1 = '0;
  logic        obj_fetch = 1'b0;
  logic [2:0]  bg_fifo [0:QUEUE_DEPTH-1];
  logic [2:0]  obj_fifo [0:QUEUE_DEPTH-1];
  int          bg_rd = QUEUE_DEPTH;
  int          obj_rd = QUEUE_DEPTH;
  logic        match_q = 1'b0;

  function automatic logic [7:0] obj_byte(input int idx, input int k);
    if (idx >= MAX_OBJS) return 8'h00;
    return line_objs[idx][8*k +: 8];
  endfunction

  // object bytes: keep the tile number inside the written tile set
  function automatic logic [7:0] obj_data(input logic [12:0] a);
    if (a[1:0] == 2'd2) return 8'($urandom_range(TILE_SET-1));
    return 8'($urandom);
  endfunction

  // eight pixels, leftmost first; extra goes to bit 2
  function automatic logic [23:0] tile_row(input logic [7:0] b0, input logic [7:0] b1,
                                           input logic extra);
    logic [23:0] row;
    row = '0;
    for (int i = 0; i < 8; i++) begin
      row[3*i +: 3] = {extra, b1[7-i], b0[7-i]};
    end
    return row;
  endfunction

  task automatic predict_dot(input logic [1:0] f, input logic [12:0] a, input logic [7:0] d,
                             output dot_result_t r);
    int base;
    int oy;
    int ox;
    int colour;
    logic [2:0] o;
    logic [7:0] pal;
    logic [23:0] row;
    r = '0;
    if (f == FUNC_TILE_WR) begin
      tile_mem[a] = d;
    end else if (f == FUNC_OBJ_WR) begin
      if (a < OBJ_BYTES) obj_mem[a] = d;
    end else if (f == FUNC_TICK) begin
      if (phase_q == PH_SEARCH) begin
        base = dot_q * 2;
        if (dot_q == 0) obj_cnt = 0;
        if (dot_q % 2 == 0 && obj_cnt < MAX_OBJS && base + 3 < OBJ_BYTES) begin
          oy = obj_mem[base];
          ox = obj_mem[base+1];
          if (ox != 0 && oy <= line_q + 16 && oy > line_q + 8) begin
            line_objs[obj_cnt] = {obj_mem[base+3], obj_mem[base+2], obj_mem[base+1],
                                  obj_mem[base]};
            obj_cnt++;
          end
        end
        if (dot_q == int'(LAST_SEARCH_DOT)) begin
          phase_q = PH_DRAW;
          col_q = 0;
          obj_fetch = 1'b0;
          bg_rd = QUEUE_DEPTH;
          obj_rd = QUEUE_DEPTH;
          obj_next = (obj_cnt > 0) ? 0 : MAX_OBJS;
          step_q = 0;
          map_col = 0;
        end
      end else if (phase_q == PH_DRAW) begin
        case (step_q)
          0: begin
            if (obj_fetch) begin
              f_y = 8'(line_q - int'(obj_byte(obj_next, 0)));
              f_tile = obj_byte(obj_next, 2);
              f_flags = obj_byte(obj_next, 3);
            end else begin
              f_y = 8'(line_q + int'(scroll_y_q));
              f_tile = tile_mem[MAP_BASE + (int'(f_y & 8'hf8) << 2) + map_col];
            end
          end
          2: f_b0 = tile_mem[int'(f_tile) * 16 + int'(f_y[2:0]) * 2];
          4: f_b1 = tile_mem[int'(f_tile) * 16 + int'(f_y[2:0]) * 2 + 1];
          6: if (!obj_fetch) map_col = (map_col + 1) % 32;
          7: begin
            if (obj_fetch) begin
              if (obj_rd >= QUEUE_DEPTH) begin
                row = tile_row(f_b0, f_b1, f_flags[PAL_FLAG_BIT]);
                for (int i = 0; i < 8; i++) obj_fifo[i] = row[3*i +: 3];
                obj_rd = 0;
              end
              obj_next++;
              if (obj_next >= obj_cnt) begin
                obj_next = MAX_OBJS;
                obj_fetch = 1'b0;
              end else if (int'(obj_byte(obj_next, 1)) - 8 > col_q) begin
                obj_fetch = 1'b0;
              end
            end else begin
              if (bg_rd >= QUEUE_DEPTH) begin
                row = tile_row(f_b0, f_b1, 1'b0);
                for (int i = 0; i < 8; i++) bg_fifo[i] = row[3*i +: 3];
                bg_rd = 0;
              end
              if (obj_next < MAX_OBJS && int'(obj_byte(obj_next, 1)) - 8 == col_q)
                obj_fetch = 1'b1;
            end
          end
          default: ;
        endcase
        step_q = (step_q + 1) % 8;
        if (!obj_fetch && bg_rd < QUEUE_DEPTH) begin
          colour = bg_fifo[bg_rd][1:0];
          bg_rd++;
          pal = bg_pal_q;
          if (obj_rd < QUEUE_DEPTH) begin
            o = obj_fifo[obj_rd];
            obj_rd++;
            if (o[1:0] != 2'b00) begin
              colour = o[1:0];
              pal = o[2] ? obj_pal1_q : obj_pal0_q;
            end
          end
          if (col_q < VIS_W) begin
            r.pixel_valid = 1'b1;
            r.pixel_x = 8'(col_q);
            r.pixel_y = 8'(line_q);
            if (!display_on_q) begin
              r.blank_pixel = 1'b1;
              r.shade = 2'd3;
            end else begin
              r.shade = 2'(pal >> (2 * colour));
            end
            col_q++;
          end
        end
        if (col_q == VIS_W) phase_q = PH_HBLANK;
      end
      dot_q++;
      if (dot_q == int'(DOTS_PER_LINE)) begin
        dot_q = 0;
        line_q++;
        if (line_q < VIS_LINES) begin
          phase_q = PH_SEARCH;
        end else if (line_q == VIS_LINES) begin
          phase_q = PH_VBLANK;
          r.vblank_irq = 1'b1;
        end else if (line_q >= int'(TOTAL_LINES)) begin
          line_q = 0;
          phase_q = PH_SEARCH;
        end
        match_q = (line_q == int'(line_cmp_q));
      end
    end
    r.mode = phase_q;
    r.line = 8'(line_q);
    r.line_match = match_q;
  endtask

  // present one request; hold it until taken, then predict
  task automatic send_request(input logic [1:0] f, input logic [12:0] a, input logic [7:0] d);
    logic take;
    dot_result_t r;
    if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    in_func <= f;
    in_mem_addr <= a;
    in_mem_data <= d;
    do begin
      @(negedge clk);
      take = in_ready;
      @(posedge clk);
    end while (!take);
    predict_dot(f, a, d, r);
    expected_dots.push_back(r);
  endtask

  // drop valid and wait for every outstanding result
  task automatic settle();
    in_valid <= 1'b0;
    while (expected_dots.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_register(input logic [2:0] idx, input logic [7:0] v);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= {idx, 2'b00};
    pwdata <= {24'h0, v};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_SCROLL_Y:   scroll_y_q = v;
      REG_BG_PAL:     bg_pal_q = v;
      REG_OBJ_PAL0:   obj_pal0_q = v;
      REG_OBJ_PAL1:   obj_pal1_q = v;
      REG_DISPLAY_ON: display_on_q = v[0];
      REG_LINE_CMP:   line_cmp_q = v;
      default: ;
    endcase
  endtask

  task automatic configure(input logic [7:0] scroll, input logic [7:0] bgp,
                           input logic [7:0] op0, input logic [7:0] op1,
                           input logic on, input logic [7:0] cmp);
    write_register(REG_SCROLL_Y, scroll);
    write_register(REG_BG_PAL, bgp);
    write_register(REG_OBJ_PAL0, op0);
    write_register(REG_OBJ_PAL1, op1);
    write_register(REG_DISPLAY_ON, {7'h0, on});
    write_register(REG_LINE_CMP, cmp);
  endtask

  task automatic random_requests(input int n);
    int pick;
    logic [12:0] oa;
    for (int k = 0; k < n; k++) begin
      pick = $urandom_range(99);
      if (pick < 94) begin
        send_request(FUNC_TICK, 13'($urandom), 8'($urandom));
      end else if (pick < 97) begin
        send_request(FUNC_TILE_WR, 13'($urandom_range(16*TILE_SET-1)), 8'($urandom));
      end else if (pick < 99) begin
        oa = $urandom_range(1) ? 13'($urandom_range(OBJ_BYTES-1)) : 13'($urandom);
        send_request(FUNC_OBJ_WR, oa, obj_data(oa));
      end else begin
        send_request(2'd3, 13'($urandom), 8'($urandom));
      end
    end
  endtask

  // the tile set, map rows 0 and 16 and every object byte are written first
  task automatic test_memory_fill();
    int oy;
    int ox;
    for (int a = 0; a < 16*TILE_SET; a++) send_request(FUNC_TILE_WR, 13'(a), 8'($urandom));
    for (int c = 0; c < 32; c++) begin
      send_request(FUNC_TILE_WR, 13'(MAP_BASE + c), 8'($urandom_range(TILE_SET-1)));
      send_request(FUNC_TILE_WR, 13'(MAP_BASE + 32*MAP_ROW_HI + c),
                   8'($urandom_range(TILE_SET-1)));
    end
    for (int s = 0; s < OBJ_BYTES / 4; s++) begin
      oy = ($urandom_range(3) == 0) ? $urandom_range(8, 160) : $urandom_range(9, 18);
      ox = ($urandom_range(3) == 0) ? $urandom_range(255) : 8 * $urandom_range(1, 20);
      send_request(FUNC_OBJ_WR, 13'(4*s), 8'(oy));
      send_request(FUNC_OBJ_WR, 13'(4*s+1), 8'(ox));
      send_request(FUNC_OBJ_WR, 13'(4*s+2), 8'($urandom_range(TILE_SET-1)));
      send_request(FUNC_OBJ_WR, 13'(4*s+3), 8'($urandom));
    end
    settle();
  endtask

  task automatic test_directed();
    send_request(FUNC_TICK, 13'h1fff, 8'hff);
    send_request(FUNC_TILE_WR, 13'h1fff, 8'hff);
    send_request(FUNC_TILE_WR, 13'(READ_TOP), 8'h00);
    send_request(FUNC_OBJ_WR, 13'h1fff, 8'hff);         // out of range, dropped
    send_request(FUNC_OBJ_WR, 13'(OBJ_BYTES), 8'h55);
    send_request(FUNC_OBJ_WR, 13'(OBJ_BYTES-1), 8'h00);
    send_request(2'd3, 13'h1fff, 8'hff);                // unused code, ignored
    send_request(2'd3, 13'h0000, 8'h00);
    for (int k = 0; k < 12; k++) send_request(FUNC_TICK, 13'h0000, 8'h00);
    settle();
  endtask

  task automatic test_plain_flow();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    configure(8'h00, 8'he4, 8'h1b, 8'h93, 1'b1, 8'd3);
    random_requests(110);
    settle();
  endtask

  task automatic test_sender_gaps();
    send_idle_pct = 49;
    recv_stall_pct = 0;
    configure(8'h83, 8'h00, 8'hff, 8'h27, 1'b1, 8'd144);
    random_requests(110);
    settle();
  endtask

  task automatic test_receiver_stalls();
    send_idle_pct = 0;
    recv_stall_pct = 49;
    configure(8'h04, 8'hff, 8'h00, 8'hff, 1'b0, 8'd255);
    hold_off_req = ~hold_off_req;   // let the block fill and back up its input
    random_requests(110);
    settle();
  endtask

  task automatic test_both_idle();
    send_idle_pct = 29;
    recv_stall_pct = 29;
    configure(8'h81, 8'h6c, 8'hd2, 8'h4e, 1'b1, 8'd0);
    random_requests(110);
    settle();
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_off_req != hold_off_seen) begin
      hold_off_seen <= hold_off_req;
      hold_off_left <= HOLD_OFF_CYCLES;
      out_ready <= 1'b0;
    end else if (hold_off_left > 0) begin
      out_ready <= 1'b0;
      hold_off_left <= hold_off_left - 1;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // handshakes are stable between the edges; sample them at the falling edge
  always @(negedge clk) begin
    dot_result_t exp_r;
    dot_result_t got_r;
    if (rst_n && out_valid && out_ready) begin
      got_r = '{out_pixel_valid, out_pixel_x, out_pixel_y, out_shade, out_blank_pixel,
                out_mode, out_line, out_line_match, out_vblank_irq};
      if (expected_dots.size() == 0) begin
        if (mismatch_count < 10) $display("unexpected result %p", got_r);
        mismatch_count++;
      end else begin
        exp_r = expected_dots.pop_front();
        if (got_r.pixel_valid !== exp_r.pixel_valid || got_r.pixel_x !== exp_r.pixel_x ||
            got_r.pixel_y !== exp_r.pixel_y || got_r.shade !== exp_r.shade ||
            got_r.blank_pixel !== exp_r.blank_pixel || got_r.mode !== exp_r.mode ||
            got_r.line !== exp_r.line || got_r.line_match !== exp_r.line_match ||
            got_r.vblank_irq !== exp_r.vblank_irq) begin
          if (mismatch_count < 10)
            $display("result mismatch: expected %p actual %p", exp_r, got_r);
          mismatch_count++;
        end
      end
    end
  end

  always @(negedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("tile_display_dot_engine test failed");
      $finish;
    end
  end

  initial begin
    for (int a = 0; a < TILE_MEM_DEPTH; a++) tile_mem[a] = '0;
    for (int a = 0; a < OBJ_BYTES; a++) obj_mem[a] = '0;
    for (int i = 0; i < MAX_OBJS; i++) line_objs[i] = '0;
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      bg_fifo[i] = '0;
      obj_fifo[i] = '0;
    end
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_memory_fill();
    test_directed();
    test_plain_flow();
    test_sender_gaps();
    test_receiver_stalls();
    test_both_idle();
    if (mismatch_count == 0 && expected_dots.size() == 0) begin
      $display("tile_display_dot_engine test passed");
    end else begin
      $display("tile_display_dot_engine test failed");
    end
    $finish;
  end

endmodule
